// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. They expect signals named clk and rst
// in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property check, switched off while reset is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked property check that also holds during reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)

`endif

`endif

// File: hdl/ras_pkg.sv
// ---------------------------------------------------------------------------
// ras_pkg
// Request codes and payload widths of the return address stack.
// ---------------------------------------------------------------------------
`default_nettype none

package ras_pkg;

  // Payload widths.
  localparam int ADDR_W = 64;
  localparam int REQ_W  = 2;

  // Request codes. The fourth code is unused and changes nothing.
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

endpackage

`default_nettype wire

// File: hdl/ras_req_if.sv
// ---------------------------------------------------------------------------
// ras_req_if
// Request channel: valid/ready handshake carrying one stack operation.
// ---------------------------------------------------------------------------
`default_nettype none

interface ras_req_if
  import ras_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] push_addr;

  modport source (output valid, output req_type, output push_addr, input ready);
  modport sink   (input valid, input req_type, input push_addr, output ready);
endinterface

`default_nettype wire

// File: hdl/ras_rsp_if.sv
// ---------------------------------------------------------------------------
// ras_rsp_if
// Response channel: valid/ready handshake carrying one predicted address.
// ---------------------------------------------------------------------------
`default_nettype none

interface ras_rsp_if
  import ras_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] return_addr;
  logic              from_empty;

  modport source (output valid, output return_addr, output from_empty, input ready);
  modport sink   (input valid, input return_addr, input from_empty, output ready);
endinterface

`default_nettype wire

// File: hdl/ras_slot_mem.sv
// ---------------------------------------------------------------------------
// ras_slot_mem
// Address slot storage: one write port and one read port with registered
// read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ras_slot_mem
  import ras_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
  input  wire logic [ADDR_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
  output logic      [ADDR_W-1:0]        rd_data
);

  logic [ADDR_W-1:0] slots [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_idx] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= slots[rd_idx];
    end
  end

endmodule

`default_nettype wire

// File: hdl/return_address_stack_unit.sv
// ---------------------------------------------------------------------------
// return_address_stack_unit
// Return address stack kept in a circular buffer of DEPTH slots.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (push, pop or flush). A push stores push_addr at
//   the fill index and makes it the top; on overflow the oldest entry is
//   overwritten. Only a pop produces a response on rsp: the top address, or
//   the last popped address with from_empty set when the stack is empty.
// Response path:
//   A pop of a non-empty stack reads the slot memory, so its response goes
//   through the registered read data and then the output register, and req
//   is held off while the memory read is pending. An empty pop answers in
//   the cycle after acceptance. Push and flush give no response.
// Throughput:
//   One push or flush per cycle while no memory read is pending; a pop of a
//   non-empty stack holds off further requests until its slot read is done.
// Stalls:
//   A pending response sits in the output register. Pushes and flushes are
//   still taken while it waits; a further pop waits until rsp drains.
// Reset:
//   Synchronous rst clears the pointers, the count, the last popped address,
//   rd_pend and out_valid. Slot contents are not cleared; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module return_address_stack_unit
  import ras_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  ras_req_if.sink   req,
  ras_rsp_if.source rsp
);

`include "assert_macros.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  // Pointer and status registers.
  logic [IDX_W-1:0]  top_index;
  logic [IDX_W-1:0]  fill_index;
  logic [OCC_W-1:0]  occupancy;
  logic [ADDR_W-1:0] last_popped;
  logic              rd_pend;

  // Output register.
  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic              out_empty;

  logic              req_fire;
  logic              is_push;
  logic              is_pop;
  logic              is_flush;
  logic              stack_empty;
  logic              out_drain;
  logic [ADDR_W-1:0] rd_data;

  assign out_drain   = out_valid && rsp.ready;
  assign stack_empty = (occupancy == '0);

  // Hold off during a memory read; hold off a pop while a held response is not drained.
  assign req.ready = !rd_pend &&
                     (!out_valid || rsp.ready || (req.req_type != REQ_POP));
  assign req_fire  = req.valid && req.ready;
  assign is_push   = req_fire && (req.req_type == REQ_PUSH);
  assign is_pop    = req_fire && (req.req_type == REQ_POP);
  assign is_flush  = req_fire && (req.req_type == REQ_FLUSH);

  // Slot storage.
  ras_slot_mem #(
    .DEPTH (DEPTH)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (is_push),
    .wr_idx  (fill_index),
    .wr_data (req.push_addr),
    .rd_en   (is_pop && !stack_empty),
    .rd_idx  (top_index),
    .rd_data (rd_data)
  );

  // Pointer updates on push, pop and flush.
  always_ff @(posedge clk) begin
    if (rst || is_flush) begin
      top_index  <= IDX_LAST;
      fill_index <= '0;
      occupancy  <= '0;
    end else if (is_push) begin
      top_index  <= fill_index;
      fill_index <= (fill_index == IDX_LAST) ? '0 : fill_index + 1'b1;
      if (occupancy < OCC_FULL) begin
        occupancy <= occupancy + 1'b1;
      end
    end else if (is_pop && !stack_empty) begin
      fill_index <= top_index;
      top_index  <= (top_index == '0) ? IDX_LAST : top_index - 1'b1;
      occupancy  <= occupancy - 1'b1;
    end
  end

  // Read-pending flag: set while the popped slot is being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= is_pop && !stack_empty;
    end
  end

  // Last popped address follows the read data.
  always_ff @(posedge clk) begin
    if (rst || is_flush) begin
      last_popped <= '0;
    end else if (rd_pend) begin
      last_popped <= rd_data;
    end
  end

  // Output register: valid control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend || (is_pop && stack_empty)) begin
      out_valid <= 1'b1;
    end else if (out_drain) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_addr  <= rd_data;
      out_empty <= 1'b0;
    end else if (is_pop && stack_empty) begin
      out_addr  <= last_popped;
      out_empty <= 1'b1;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.return_addr = out_addr;
  assign rsp.from_empty  = out_empty;

  // Checks.
  `ASSERT_CLK(a_occ_bound, occupancy <= OCC_FULL)
  `ASSERT_CLK(a_out_free_on_read, rd_pend |-> !out_valid)
  `ASSERT_CLK(a_read_one_cycle, rd_pend |=> !rd_pend && out_valid && !out_empty)
  `ASSERT_CLK(a_empty_pop_resp, (is_pop && stack_empty) |=> out_valid && out_empty)
  `ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && !rd_pend && occupancy == '0)

endmodule

`default_nettype wire

// File: test/return_address_stack_unit_test.sv
// ---------------------------------------------------------------------------
// return_address_stack_unit_test
// Self-checking test of the return address stack. A predictor tracks the
// circular buffer, the top and fill indices, the occupancy and the last
// popped address. It forms the expected response for every accepted pop, and
// each response taken from the block is compared field by field. Directed
// requests cover the field extremes, the unused request code, empty pops,
// flush and overflow. Random call/return nests, noise and stall bursts follow.
// ---------------------------------------------------------------------------

module return_address_stack_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ras_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1850;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_NS = 5_000_000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              from_empty;
  } return_t;

  // Tracks the stack and holds the responses still owed by the block.
  class return_predictor;
    logic [ADDR_W-1:0] slots [STACK_DEPTH];
    logic [IDX_W-1:0]  top_idx;
    logic [IDX_W-1:0]  fill_idx;
    logic [IDX_W:0]    depth_used;
    logic [ADDR_W-1:0] last_return;
    return_t           pending_returns [$];
    int errors, pushes, pops, empty_pops, overwrites, flushes, ignored;

    function new();
      foreach (slots[i]) slots[i] = '0;
      clear_pointers();
    endfunction

    function void clear_pointers();
      top_idx     = IDX_W'(STACK_DEPTH - 1);
      fill_idx    = '0;
      depth_used  = '0;
      last_return = '0;
    endfunction

    // Apply one accepted request to the stack.
    function void note_request(input logic [REQ_W-1:0] kind,
                               input logic [ADDR_W-1:0] addr);
      return_t ret;
      case (kind)
        REQ_PUSH: begin
          // A push onto a full stack overwrites the oldest entry.
          if (depth_used == STACK_DEPTH) overwrites++;
          slots[fill_idx] = addr;
          top_idx = fill_idx;
          fill_idx = (fill_idx == STACK_DEPTH - 1) ? '0 : fill_idx + 1'b1;
          if (depth_used < STACK_DEPTH) depth_used++;
          pushes++;
        end
        REQ_POP: begin
          pops++;
          if (depth_used == 0) begin
            // Nothing on the stack: the last popped address comes back.
            ret.addr = last_return;
            ret.from_empty = 1'b1;
            empty_pops++;
          end else begin
            ret.addr = slots[top_idx];
            ret.from_empty = 1'b0;
            fill_idx = top_idx;
            top_idx = (top_idx == 0) ? IDX_W'(STACK_DEPTH - 1) : top_idx - 1'b1;
            depth_used--;
            last_return = ret.addr;
          end
          pending_returns.push_back(ret);
        end
        REQ_FLUSH: begin
          clear_pointers();
          flushes++;
        end
        default: ignored++;
      endcase
    endfunction

    // Compare one accepted response with the oldest one owed.
    function void check_return(input logic [ADDR_W-1:0] addr, input logic from_empty);
      return_t want;
      if (pending_returns.size() == 0) begin
        errors++;
        $display("%0t: response with none owed: return_addr %h from_empty %0b",
                 $time, addr, from_empty);
        return;
      end
      want = pending_returns.pop_front();
      if (addr !== want.addr) begin
        errors++;
        $display("%0t: return_addr expected %h, got %h", $time, want.addr, addr);
      end
      if (from_empty !== want.from_empty) begin
        errors++;
        $display("%0t: from_empty expected %0b, got %0b", $time, want.from_empty,
                 from_empty);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ras_req_if req ();
  ras_rsp_if rsp ();

  return_address_stack_unit #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  return_predictor board;
  bit no_idle = 1'b0;
  bit hold_returns = 1'b0;
  int counted_requests = 0;

  // Clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [ADDR_W-1:0] draw_addr();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ADDR_W'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.push_addr <= addr;
    do @(posedge clk); while (!req.ready);
    board.note_request(kind, addr);
    if (kind != REQ_UNUSED) counted_requests++;
  endtask

  // A call/return nest: a run of pushes followed by a run of pops.
  task automatic send_nest(input int n_push, input int n_pop);
    repeat (n_push) send_request(REQ_PUSH, draw_addr());
    repeat (n_pop) send_request(REQ_POP, draw_addr());
  endtask

  // The request side goes idle until every owed response has come back.
  task automatic wait_returns_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (board.pending_returns.size() != 0);
  endtask

  // The response side holds off while pops keep coming, so the block backs up.
  task automatic stall_burst();
    hold_returns = 1'b1;
    send_nest(8, 10);
  endtask

  // Request side: reset, directed requests, then random sequences.
  initial begin
    int start_count;
    int mode;
    board = new();
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.req_type <= REQ_PUSH;
    req.push_addr <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Largest address in and out, then a pop of the now empty stack.
    send_request(REQ_PUSH, '1);
    send_request(REQ_POP, '0);
    send_request(REQ_POP, draw_addr());
    // Smallest address; the unused request code must leave the stack alone.
    send_request(REQ_PUSH, '0);
    send_request(REQ_UNUSED, '1);
    send_request(REQ_POP, '1);
    // A flush clears the last popped address as well.
    send_request(REQ_FLUSH, '1);
    send_request(REQ_POP, draw_addr());
    // One push more than the stack holds overwrites the oldest entry.
    for (int i = 0; i < STACK_DEPTH + 1; i++) send_request(REQ_PUSH, {$urandom, 32'(i)});

    // Back-pressure from the response side, then a full pause.
    stall_burst();
    wait_returns_drained();

    // Random part: mostly well-formed nests, with noise mixed in.
    start_count = counted_requests;
    while (counted_requests - start_count < RANDOM_REQUESTS) begin
      mode = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 4) == 0);
      if (mode < 55) begin
        int n_push;
        n_push = $urandom_range(1, 20);
        send_nest(n_push, $urandom_range(0, n_push + 3));
      end else if (mode < 75) begin
        repeat ($urandom_range(1, 8)) send_request(REQ_W'($urandom_range(0, 3)), draw_addr());
      end else if (mode < 85) begin
        repeat ($urandom_range(1, 6)) send_request(REQ_POP, draw_addr());
      end else if (mode < 92) begin
        send_request(REQ_FLUSH, draw_addr());
        send_nest($urandom_range(1, 6), $urandom_range(0, 8));
      end else if (mode < 96) begin
        stall_burst();
      end else begin
        wait_returns_drained();
      end
    end

    wait_returns_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d pushes (%0d onto a full stack) and %0d pops (%0d on an empty stack),",
             board.pushes, board.overwrites, board.pops, board.empty_pops);
    $display("%0d flushes and %0d unused request codes; %0d mismatches.",
             board.flushes, board.ignored, board.errors);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Response side: random ready gaps, an occasional long hold-off.
  initial begin
    int gap;
    rsp.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_returns) begin
        hold_returns = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          rsp.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      board.check_return(rsp.return_addr, rsp.from_empty);
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #(WATCHDOG_NS);
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule
